// File: hw/rtl/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and codes for the positional list engine: request and
// result transactions, request function codes, status codes and the
// control bundle that drives the cell chain.
// ----------------------------------------------------------------------------
package plc_pkg;

  // request function codes
  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_AT    = 3'd2;
  localparam logic [2:0] FN_REM_FRONT = 3'd3;
  localparam logic [2:0] FN_REM_BACK  = 3'd4;
  localparam logic [2:0] FN_REM_AT    = 3'd5;
  localparam logic [2:0] FN_SEARCH    = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // request transaction
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;
  } plc_req_t;

  // result transaction
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_out;
    logic [3:0]         found_at;
    logic [4:0]         length;
  } plc_rsp_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } plc_cell_op_e;

  // control bundle broadcast along the cell chain
  typedef struct packed {
    plc_cell_op_e       op;
    logic signed [31:0] ins_value;
    logic signed [31:0] key;
  } plc_cell_ctrl_t;

endpackage

// File: hw/rtl/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell
// One list cell: holds the entry at a fixed position, takes its left or
// right neighbor's entry when the list opens or closes around a position,
// and compares its entry against the search key.
// ----------------------------------------------------------------------------
module plc_cell
  import plc_pkg::*;
#(
  parameter int unsigned CW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  plc_cell_ctrl_t     ctrl_i,
  input  logic [CW-1:0]      pos_i,
  input  logic [CW-1:0]      count_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] value_o,
  output logic               match_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic signed [31:0] value_q;
  logic signed [31:0] value_d;

  // next entry: open a gap at pos on insert, close it on remove
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          value_d = left_i;
        end else if (MyIdx == pos_i) begin
          value_d = ctrl_i.ins_value;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= pos_i) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // only live entries take part in a search
  assign match_o = (MyIdx < count_i) && (value_q == ctrl_i.key);
  assign value_o = value_q;

endmodule

// File: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit entries held in a chain of cells, with
// insert and remove at front, back or position, and search.
// ----------------------------------------------------------------------------
// Each request passes through three steps: the idle step that accepts it, an
// execute step in which every cell of the chain shifts toward or away from
// the target position and compares itself against the key, and a resolve
// step that resolves the removed entry and the first match into the result
// register. The engine handles one request at a time; the next request is
// accepted while a finished result still sits in the output register, and
// the sequencer waits in its resolve step only if that register is still
// occupied. There is no clearing pass: cells at or above the entry count are
// never read. found_at and length carry the low 4 and 5 bits of the position
// and count when CAPACITY exceeds 16.
// ----------------------------------------------------------------------------
module positional_list_engine
  import plc_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  plc_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output plc_rsp_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESOLVE
  } state_e;

  state_e             state_q;
  plc_req_t           req_q;
  logic [CW-1:0]      count_q;
  logic [2:0]         status_q;
  logic signed [31:0] data_q;
  logic               srch_q;
  logic [CAPACITY-1:0] match_q;
  logic               out_valid_q;
  plc_rsp_t           out_q;

  plc_cell_ctrl_t     cell_ctrl;
  logic [CW-1:0]      cell_pos;
  logic [CW-1:0]      count_d;
  logic [2:0]         dec_status;
  logic               dec_srch;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      cnt_ext;
  logic               full;
  logic               empty;

  logic signed [31:0] cell_val  [CAPACITY];
  logic signed [31:0] left_val  [CAPACITY];
  logic signed [31:0] right_val [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic signed [31:0] rem_data;
  logic [IW-1:0]      found_idx;
  logic               any_match;
  plc_rsp_t           rsp;

  assign pos_ext = PW'(req_q.position);
  assign cnt_ext = PW'(count_q);
  assign full    = (count_q == CapCount);
  assign empty   = (count_q == '0);

  // request decode, only drives the chain in the execute step
  always_comb begin
    cell_ctrl.op        = CELL_HOLD;
    cell_ctrl.ins_value = req_q.value;
    cell_ctrl.key       = req_q.value;
    cell_pos            = '0;
    count_d             = count_q;
    dec_status          = ST_OK;
    dec_srch            = 1'b0;
    if (state_q == S_EXEC) begin
      case (req_q.func)
        FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
          if (full) begin
            dec_status = ST_FULL;
          end else if (req_q.func == FN_INS_AT && pos_ext > cnt_ext) begin
            dec_status = ST_BADPOS;
          end else begin
            cell_ctrl.op = CELL_INSERT;
            count_d      = CW'(count_q + CW'(1));
            case (req_q.func)
              FN_INS_FRONT: cell_pos = '0;
              FN_INS_BACK:  cell_pos = count_q;
              default:      cell_pos = CW'(pos_ext);
            endcase
          end
        end
        FN_REM_FRONT, FN_REM_BACK, FN_REM_AT: begin
          if (empty) begin
            dec_status = ST_EMPTY;
          end else if (req_q.func == FN_REM_AT && pos_ext >= cnt_ext) begin
            dec_status = ST_BADPOS;
          end else begin
            cell_ctrl.op = CELL_REMOVE;
            count_d      = CW'(count_q - CW'(1));
            case (req_q.func)
              FN_REM_FRONT: cell_pos = '0;
              FN_REM_BACK:  cell_pos = CW'(count_q - CW'(1));
              default:      cell_pos = CW'(pos_ext);
            endcase
          end
        end
        FN_SEARCH: begin
          if (empty) begin
            dec_status = ST_EMPTY;
          end else begin
            dec_srch = 1'b1;
          end
        end
        default: dec_status = ST_OK;
      endcase
    end
  end

  // cell chain with neighbor links
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = '0;
    end else begin : g_left
      assign left_val[g] = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_val[g] = '0;
    end else begin : g_right
      assign right_val[g] = cell_val[g+1];
    end

    plc_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .left_i  (left_val[g]),
      .right_i (right_val[g]),
      .value_o (cell_val[g]),
      .match_o (cell_match[g])
    );
  end

  // entry leaving the list on a removal
  always_comb begin
    rem_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CW'(i) == cell_pos) begin
        rem_data = rem_data | cell_val[i];
      end
    end
  end

  // first match wins
  always_comb begin
    found_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        found_idx = IW'(i);
      end
    end
  end
  assign any_match = |match_q;

  // result assembly
  always_comb begin
    rsp.status   = status_q;
    rsp.data_out = data_q;
    rsp.found_at = '0;
    rsp.length   = 5'(count_q);
    if (srch_q) begin
      rsp.status = any_match ? ST_OK : ST_NOTFOUND;
      if (any_match) begin
        rsp.found_at = 4'(found_idx);
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      req_q       <= '0;
      status_q    <= ST_OK;
      data_q      <= '0;
      srch_q      <= 1'b0;
      match_q     <= '0;
      out_q       <= '0;
    end else begin
      // result valid: set by a finished request, cleared once taken
      if (state_q == S_RESOLVE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          count_q  <= count_d;
          status_q <= dec_status;
          srch_q   <= dec_srch;
          match_q  <= cell_match;
          data_q   <= (cell_ctrl.op == CELL_REMOVE) ? rem_data : '0;
          state_q  <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q   <= rsp;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the entry count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CapCount)
    else $error("entry count above capacity");

  // the chain only opens a gap when there is room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_ctrl.op == CELL_INSERT) |-> (count_q < CapCount))
    else $error("insert issued to a full list");

  // a request is executed in the cycle right after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  // a fresh result reports the updated count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && out_q.length == 5'(count_q)))
    else $error("result length differs from entry count");

endmodule
